// ===== src/swei_pkg.sv =====
// Shared types and constants for the sphere wireframe edge indexer.
`default_nettype none

package swei_pkg;

   // Edge group codes, also used as the walk phase
   localparam logic [1:0] GROUP_TOP    = 2'd0;
   localparam logic [1:0] GROUP_VERT   = 2'd1;
   localparam logic [1:0] GROUP_BOTTOM = 2'd2;
   localparam logic [1:0] GROUP_RING   = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_STACK_COUNT = 2'd0;
   localparam logic [1:0] CSR_SLICE_COUNT = 2'd1;

   // Reset values of the count registers
   localparam logic [8:0] STACK_COUNT_RESET = 9'd16;
   localparam logic [8:0] SLICE_COUNT_RESET = 9'd16;

   // Smallest usable stack or slice count
   localparam logic [8:0] COUNT_MIN = 9'd3;

   // Position of the walk over the sphere
   typedef struct packed {
      logic [1:0]  phase;
      logic [8:0]  ring;
      logic [8:0]  column;
      logic [15:0] base;
   } walk_state_type;

   // One produced edge
   typedef struct packed {
      logic [15:0] first_index;
      logic [15:0] second_index;
      logic [1:0]  edge_group;
      logic        last_edge;
   } edge_type;

   // Walk position at the first top-fan edge
   localparam walk_state_type WALK_START = '{
      phase:  GROUP_TOP,
      ring:   9'd0,
      column: 9'd0,
      base:   16'd1
   };

endpackage

`default_nettype wire

// ===== src/swei_edge_gen.sv =====
// Combinational edge generator: current walk position to edge and next position.
`default_nettype none

module swei_edge_gen #(
   parameter int MAX_STACKS = 256,
   parameter int MAX_SLICES = 256
) (
   input  wire logic [8:0]             stack_count,
   input  wire logic [8:0]             slice_count,
   input  wire logic                   restart,
   input  wire swei_pkg::walk_state_type walk_cur,
   output swei_pkg::walk_state_type    walk_next,
   output swei_pkg::edge_type          edge_out
);

   localparam logic [8:0] STACK_LIMIT = 9'(MAX_STACKS);
   localparam logic [8:0] SLICE_LIMIT = 9'(MAX_SLICES);

   logic [8:0]                s_cnt;
   logic [8:0]                l_cnt;
   logic [15:0]               vert_count;
   swei_pkg::walk_state_type  cur;
   logic [9:0]                col_inc;
   logic                      row_end;
   logic [9:0]                ring_inc;
   logic [15:0]               col_ext;
   logic [15:0]               l_ext;
   logic [15:0]               base_step;

   // Clamp the counts into the usable range
   always_comb begin
      if (stack_count < swei_pkg::COUNT_MIN) s_cnt = swei_pkg::COUNT_MIN;
      else if (stack_count > STACK_LIMIT)    s_cnt = STACK_LIMIT;
      else                                   s_cnt = stack_count;
      if (slice_count < swei_pkg::COUNT_MIN) l_cnt = swei_pkg::COUNT_MIN;
      else if (slice_count > SLICE_LIMIT)    l_cnt = SLICE_LIMIT;
      else                                   l_cnt = slice_count;
   end

   // Vertex count: (stacks - 2) * slices + 2
   assign vert_count = 16'(({7'd0, s_cnt} - 16'd2) * {7'd0, l_cnt}) + 16'd2;

   assign cur       = restart ? swei_pkg::WALK_START : walk_cur;
   assign col_inc   = {1'b0, cur.column} + 10'd1;
   assign row_end   = (col_inc >= {1'b0, l_cnt});
   assign ring_inc  = {1'b0, cur.ring} + 10'd1;
   assign col_ext   = {7'd0, cur.column};
   assign l_ext     = {7'd0, l_cnt};
   assign base_step = cur.base + l_ext;

   // Edge and next position per group
   always_comb begin
      walk_next             = cur;
      walk_next.column      = row_end ? 9'd0 : col_inc[8:0];
      edge_out.edge_group   = cur.phase;
      edge_out.last_edge    = 1'b0;
      edge_out.first_index  = '0;
      edge_out.second_index = '0;
      case (cur.phase)
         swei_pkg::GROUP_TOP: begin
            edge_out.first_index  = 16'd0;
            edge_out.second_index = 16'd1 + col_ext;
            if (row_end) begin
               walk_next.phase = (s_cnt > swei_pkg::COUNT_MIN) ? swei_pkg::GROUP_VERT
                                                               : swei_pkg::GROUP_BOTTOM;
               walk_next.ring  = 9'd0;
               walk_next.base  = 16'd1;
            end
         end
         swei_pkg::GROUP_VERT: begin
            edge_out.first_index  = cur.base + col_ext;
            edge_out.second_index = base_step + col_ext;
            if (row_end) begin
               walk_next.ring = ring_inc[8:0];
               walk_next.base = base_step;
               if (ring_inc >= ({1'b0, s_cnt} - 10'd3)) begin
                  walk_next.phase = swei_pkg::GROUP_BOTTOM;
               end
            end
         end
         swei_pkg::GROUP_BOTTOM: begin
            edge_out.first_index  = vert_count - 16'd1;
            edge_out.second_index = vert_count - 16'd2 - col_ext;
            if (row_end) begin
               walk_next.phase = swei_pkg::GROUP_RING;
               walk_next.ring  = 9'd0;
               walk_next.base  = 16'd1;
            end
         end
         default: begin
            edge_out.first_index  = cur.base + col_ext;
            edge_out.second_index = cur.base + (row_end ? 16'd0 : {6'd0, col_inc});
            if (row_end) begin
               walk_next.ring = ring_inc[8:0];
               walk_next.base = base_step;
               if (ring_inc >= ({1'b0, s_cnt} - 10'd2)) begin
                  edge_out.last_edge = 1'b1;
               end
            end
         end
      endcase
      // Wrap after the final ring edge
      if (edge_out.last_edge) begin
         walk_next = swei_pkg::WALK_START;
      end
   end

endmodule

`default_nettype wire

// ===== src/sphere_wireframe_edge_indexer.sv =====
// Top level of the sphere wireframe edge indexer: registers, handshakes, edge output stage.
`default_nettype none

// Produces the line-list edges of a UV sphere, one edge per accepted request.
// Request channel (req_*): each transfer carries req_restart; when set, the
//   walk returns to the first top-fan edge before this edge is produced.
// Response channel (rsp_*): one transfer per request with both vertex
//   indexes, the edge group and a flag on the final edge of the sphere.
// CSR port (csr_*): write-only; index 0 is the stack count, index 1 the
//   slice count. A write to index 0 or 1 also returns the walk to the first edge.
// Latency: the edge appears on rsp_* in the cycle after the request
//   transfer. Throughput: one edge per cycle unless rsp_ready stalls it; the
//   walk state and the single output register both update in the transfer cycle.
// Stall: req_ready is high while the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds exactly one edge.
// Reset: counts return to 16 stacks and 16 slices, the walk to the first
//   top-fan edge, and the output register is emptied.
module sphere_wireframe_edge_indexer #(
   parameter int MAX_STACKS = 256,
   parameter int MAX_SLICES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_first_index,
   output logic [15:0]      rsp_second_index,
   output logic [1:0]       rsp_edge_group,
   output logic             rsp_last_edge,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [8:0]  csr_wdata
);

   logic [8:0]               stack_count_ff;
   logic [8:0]               slice_count_ff;
   swei_pkg::walk_state_type walk_ff;
   swei_pkg::walk_state_type walk_in;
   swei_pkg::edge_type       edge_in;
   swei_pkg::edge_type       edge_ff;
   logic                     rsp_valid_ff;
   logic                     req_xfer;
   logic                     csr_hit;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_hit   = csr_write_enable && ((csr_index == swei_pkg::CSR_STACK_COUNT) ||
                                           (csr_index == swei_pkg::CSR_SLICE_COUNT));

   // Edge computation from the current walk position
   swei_edge_gen #(
      .MAX_STACKS (MAX_STACKS),
      .MAX_SLICES (MAX_SLICES)
   ) u_edge_gen (
      .stack_count (stack_count_ff),
      .slice_count (slice_count_ff),
      .restart     (req_restart),
      .walk_cur    (walk_ff),
      .walk_next   (walk_in),
      .edge_out    (edge_in)
   );

   // Count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= swei_pkg::STACK_COUNT_RESET;
         slice_count_ff <= swei_pkg::SLICE_COUNT_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == swei_pkg::CSR_STACK_COUNT) stack_count_ff <= csr_wdata;
         if (csr_index == swei_pkg::CSR_SLICE_COUNT) slice_count_ff <= csr_wdata;
      end
   end

   // Walk position
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         walk_ff <= swei_pkg::WALK_START;
      end else if (req_xfer) begin
         walk_ff <= walk_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         edge_ff <= edge_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_index  = edge_ff.first_index;
   assign rsp_second_index = edge_ff.second_index;
   assign rsp_edge_group   = edge_ff.edge_group;
   assign rsp_last_edge    = edge_ff.last_edge;

`ifndef SYNTHESIS
   // The final edge is always a ring edge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_edge |-> rsp_edge_group == swei_pkg::GROUP_RING)
      else $error("last edge outside ring group");

   // Top-fan edges start at the top pole
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_group == swei_pkg::GROUP_TOP |-> rsp_first_index == 16'd0)
      else $error("top fan edge not at pole");

   // After the final edge the walk wraps to the first edge
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && edge_in.last_edge && !csr_hit |=> walk_ff == swei_pkg::WALK_START)
      else $error("walk did not wrap after last edge");

   // An empty output register never blocks requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request blocked with empty output");
`endif

endmodule

`default_nettype wire
